>>> hw/rtl/tct_pkg.sv
// ----------------------------------------------------------------------------
// tct_pkg
// Shared constants, types and helpers of the text console teletype.
// ----------------------------------------------------------------------------
package tct_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELLS      = COLUMNS * ROWS;
   localparam int MOVE_CELLS = (ROWS - 1) * COLUMNS;
   localparam int ADDR_W     = $clog2(CELLS);
   localparam int COL_W      = 7;
   localparam int ROW_W      = 5;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [15:0]       cell_type;

   localparam logic [7:0] ATTR_NORMAL = 8'h07;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_CR     = 8'h0d;
   localparam logic [7:0] CHAR_LF     = 8'h0a;
   localparam logic [7:0] CHAR_BS     = 8'h08;
   localparam cell_type   BLANK_CELL  = {ATTR_NORMAL, CHAR_SPACE};

   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_SET   = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      cell_type wr_data;
      addr_type rd_addr;
   } mem_req_type;

   function automatic addr_type cell_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
      addr_type base;
      base = ADDR_W'(r) * ADDR_W'(COLUMNS);
      return base + ADDR_W'(c);
   endfunction

endpackage

>>> hw/rtl/tct_screen_ram.sv
// ----------------------------------------------------------------------------
// tct_screen_ram
// Screen cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tct_screen_ram (
   input  logic                  clock,
   input  tct_pkg::mem_req_type  mem_req,
   output tct_pkg::cell_type     rd_data
);
   import tct_pkg::*;

   cell_type mem [CELLS];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[mem_req.rd_addr];
   end

endmodule

>>> hw/rtl/tct_ctrl.sv
// ----------------------------------------------------------------------------
// tct_ctrl
// Command sequencer: cursor, fill and scroll sweeps, response register.
// ----------------------------------------------------------------------------
module tct_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_command,
   input  logic [7:0]                    req_char_code,
   input  logic [tct_pkg::COL_W-1:0]     req_col,
   input  logic [tct_pkg::ROW_W-1:0]     req_row,
   output logic                          rsp_valid,
   output logic [tct_pkg::COL_W-1:0]     rsp_cursor_col,
   output logic [tct_pkg::ROW_W-1:0]     rsp_cursor_row,
   output logic [7:0]                    rsp_cell_char,
   output logic [7:0]                    rsp_cell_attr,
   output tct_pkg::mem_req_type          mem_req,
   input  tct_pkg::cell_type             mem_rd_data
);
   import tct_pkg::*;

   localparam logic [2:0] S_FILL   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_SCROLL = 3'd3;
   localparam logic [2:0] S_DRAIN  = 3'd4;

   logic [2:0]       state_ff, state_in;
   addr_type         cnt_ff, cnt_in;
   logic [COL_W-1:0] cur_col_ff, cur_col_in;
   logic [ROW_W-1:0] cur_row_ff, cur_row_in;
   logic             clr_rsp_ff, clr_rsp_in;
   logic             wr_v_ff, wr_v_in;
   addr_type         wr_addr_ff, wr_addr_in;
   logic             wr_blank_ff, wr_blank_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_char_ff, rsp_char_in;
   logic [7:0]       rsp_attr_ff, rsp_attr_in;

   logic             accept;
   logic [COL_W-1:0] clamp_col;
   logic [ROW_W-1:0] clamp_row;
   logic [COL_W-1:0] put_col;
   logic [ROW_W-1:0] put_row;
   logic             printable;
   logic             last_cell;

   assign accept    = start && (state_ff == S_IDLE);
   assign last_cell = (cnt_ff == addr_type'(CELLS - 1));
   assign clamp_col = (req_col >= COL_W'(COLUMNS)) ? COL_W'(COLUMNS - 1) : req_col;
   assign clamp_row = (req_row >= ROW_W'(ROWS)) ? ROW_W'(ROWS - 1) : req_row;
   assign printable = (req_char_code != CHAR_CR) && (req_char_code != CHAR_LF)
                      && (req_char_code != CHAR_BS);

   always_comb begin
      put_col = cur_col_ff;
      put_row = cur_row_ff;
      priority if (req_char_code == CHAR_CR) begin
         put_col = '0;
      end else if (req_char_code == CHAR_LF) begin
         put_col = '0;
         put_row = cur_row_ff + ROW_W'(1);
      end else if (req_char_code == CHAR_BS) begin
         if (cur_col_ff != '0) begin
            put_col = cur_col_ff - COL_W'(1);
         end
      end else begin
         if (cur_col_ff >= COL_W'(COLUMNS - 1)) begin
            put_col = '0;
            put_row = cur_row_ff + ROW_W'(1);
         end else begin
            put_col = cur_col_ff + COL_W'(1);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      clr_rsp_in   = clr_rsp_ff;
      wr_v_in      = 1'b0;
      wr_addr_in   = cnt_ff;
      wr_blank_in  = (cnt_ff >= addr_type'(MOVE_CELLS));
      rsp_valid_in = 1'b0;
      rsp_char_in  = '0;
      rsp_attr_in  = '0;
      mem_req      = '{wr_en: 1'b0, wr_addr: cnt_ff, wr_data: BLANK_CELL, rd_addr: cnt_ff};

      // delayed write of the scroll copy
      if (wr_v_ff) begin
         mem_req.wr_en   = 1'b1;
         mem_req.wr_addr = wr_addr_ff;
         mem_req.wr_data = wr_blank_ff ? BLANK_CELL : mem_rd_data;
      end

      unique case (state_ff)
         S_FILL: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cnt_ff;
            mem_req.wr_data = BLANK_CELL;
            cnt_in          = cnt_ff + addr_type'(1);
            if (last_cell) begin
               state_in     = S_IDLE;
               cnt_in       = '0;
               rsp_valid_in = clr_rsp_ff;
               clr_rsp_in   = 1'b0;
            end
         end
         S_IDLE: begin
            if (accept) begin
               unique case (req_command)
                  CMD_PUT: begin
                     if (printable) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = cell_addr(cur_row_ff, cur_col_ff);
                        mem_req.wr_data = {ATTR_NORMAL, req_char_code};
                     end
                     if (put_row >= ROW_W'(ROWS)) begin
                        state_in   = S_SCROLL;
                        cnt_in     = '0;
                        cur_col_in = '0;
                        cur_row_in = ROW_W'(ROWS - 1);
                     end else begin
                        cur_col_in   = put_col;
                        cur_row_in   = put_row;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  CMD_SET: begin
                     cur_col_in   = clamp_col;
                     cur_row_in   = clamp_row;
                     rsp_valid_in = 1'b1;
                  end
                  CMD_CLEAR: begin
                     cur_col_in = '0;
                     cur_row_in = '0;
                     cnt_in     = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = S_FILL;
                  end
                  CMD_READ: begin
                     mem_req.rd_addr = cell_addr(clamp_row, clamp_col);
                     state_in        = S_READ;
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = mem_rd_data[7:0];
            rsp_attr_in  = mem_rd_data[15:8];
            state_in     = S_IDLE;
         end
         S_SCROLL: begin
            if (cnt_ff < addr_type'(MOVE_CELLS)) begin
               mem_req.rd_addr = cnt_ff + addr_type'(COLUMNS);
            end
            wr_v_in = 1'b1;
            cnt_in  = cnt_ff + addr_type'(1);
            if (last_cell) begin
               cnt_in   = '0;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FILL;
         cnt_ff       <= '0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         wr_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         clr_rsp_ff   <= clr_rsp_in;
         wr_v_ff      <= wr_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff  <= wr_addr_in;
      wr_blank_ff <= wr_blank_in;
      rsp_char_ff <= rsp_char_in;
      rsp_attr_ff <= rsp_attr_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_col = cur_col_ff;
   assign rsp_cursor_row = cur_row_ff;
   assign rsp_cell_char  = rsp_char_ff;
   assign rsp_cell_attr  = rsp_attr_ff;

endmodule

>>> hw/rtl/text_console_teletype.sv
// ----------------------------------------------------------------------------
// text_console_teletype
// 80x25 text screen with cursor, control characters and scrolling.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfer happens on a clock edge with start high and busy low;
//   req_command selects put character, set cursor, clear and home, or read
//   cell. Every command gives exactly one response: rsp_valid is high for
//   one cycle with the cursor after the command and, for read cell, the
//   stored character and attribute (zero otherwise).
//   Put character without scroll and set cursor respond in the cycle after
//   the transfer and can be issued every cycle. Read cell responds through
//   the registered read of the cell store and then the response register.
//   A put that runs past the last row scrolls the store one cell per cycle
//   and responds after the sweep and a drain state; clear and home sweeps
//   the store and responds when the sweep is done. busy is high throughout.
//   Reset: the cursor goes home and a clearing pass blanks the store to
//   spaces with attribute 07; busy stays high until done.
//   The receiver cannot stall: each response is taken in its cycle.
// ----------------------------------------------------------------------------
module text_console_teletype (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_command,
   input  logic [7:0]                req_char_code,
   input  logic [tct_pkg::COL_W-1:0] req_col,
   input  logic [tct_pkg::ROW_W-1:0] req_row,
   output logic                      rsp_valid,
   output logic [tct_pkg::COL_W-1:0] rsp_cursor_col,
   output logic [tct_pkg::ROW_W-1:0] rsp_cursor_row,
   output logic [7:0]                rsp_cell_char,
   output logic [7:0]                rsp_cell_attr
);
   import tct_pkg::*;

   mem_req_type mem_req;
   cell_type    mem_rd_data;

   tct_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_char_code  (req_char_code),
      .req_col        (req_col),
      .req_row        (req_row),
      .rsp_valid      (rsp_valid),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cell_attr  (rsp_cell_attr),
      .mem_req        (mem_req),
      .mem_rd_data    (mem_rd_data)
   );

   tct_screen_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

endmodule

>>> hw/rtl/tct_checker.sv
// ----------------------------------------------------------------------------
// tct_checker
// Port-level checks of the text console teletype, bound to the top level.
// ----------------------------------------------------------------------------
module tct_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic [1:0]                req_command,
   input logic [7:0]                req_char_code,
   input logic [tct_pkg::COL_W-1:0] req_col,
   input logic [tct_pkg::ROW_W-1:0] req_row,
   input logic                      rsp_valid,
   input logic [tct_pkg::COL_W-1:0] rsp_cursor_col,
   input logic [tct_pkg::ROW_W-1:0] rsp_cursor_row,
   input logic [7:0]                rsp_cell_char,
   input logic [7:0]                rsp_cell_attr
);
   import tct_pkg::*;

   logic xfer;
   assign xfer = start && !busy;

   a_reset_sweep: assert property (@(posedge clock) reset |=> busy)
      else $error("store not swept after reset");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cursor_col < COL_W'(COLUMNS)) && (rsp_cursor_row < ROW_W'(ROWS)))
      else $error("cursor out of screen");

   a_set_cursor: assert property (@(posedge clock) disable iff (reset)
      (xfer && req_command == CMD_SET) |=> rsp_valid
         && (rsp_cursor_col == (($past(req_col) >= COL_W'(COLUMNS)) ?
                                COL_W'(COLUMNS - 1) : $past(req_col)))
         && (rsp_cursor_row == (($past(req_row) >= ROW_W'(ROWS)) ?
                                ROW_W'(ROWS - 1) : $past(req_row)))
         && (rsp_cell_char == 8'h00) && (rsp_cell_attr == 8'h00))
      else $error("set cursor response wrong");

   a_carriage_return: assert property (@(posedge clock) disable iff (reset)
      (xfer && req_command == CMD_PUT && req_char_code == CHAR_CR) |=> rsp_valid
         && (rsp_cursor_col == '0) && $stable(rsp_cursor_row))
      else $error("carriage return response wrong");

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      (xfer && req_command == CMD_CLEAR) |=> busy && !rsp_valid
         && (rsp_cursor_col == '0) && (rsp_cursor_row == '0))
      else $error("clear did not start a sweep");

endmodule

bind text_console_teletype tct_checker u_tct_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_command    (req_command),
   .req_char_code  (req_char_code),
   .req_col        (req_col),
   .req_row        (req_row),
   .rsp_valid      (rsp_valid),
   .rsp_cursor_col (rsp_cursor_col),
   .rsp_cursor_row (rsp_cursor_row),
   .rsp_cell_char  (rsp_cell_char),
   .rsp_cell_attr  (rsp_cell_attr)
);
